// ===== hw/rtl/gscal_pkg.sv =====
// ----------------------------------------------------------------------------
// gscal_pkg
// shared types, codes and constants of the gas sensor calibration block
// ----------------------------------------------------------------------------
package gscal_pkg;

    localparam int ADC_BITS_DEF = 10;
    localparam int ADC_PORT_W   = 10;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int DIV_NUM_W    = 48;
    localparam int DIV_DEN_W    = 32;
    localparam int DIV_CNT_W    = 6;
    localparam int SUM_W        = 40;
    localparam int CNT_W        = 9;
    localparam int MS_PER_S     = 1000;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREHEAT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_RES  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_AIR_FACT  = 3'd5;

    // register reset values
    localparam logic [9:0]  RST_THRESHOLD = 10'd1000;
    localparam logic [11:0] RST_PREHEAT   = 12'd20;
    localparam logic [15:0] RST_INTERVAL  = 16'd50;
    localparam logic [7:0]  RST_COUNT     = 8'd5;
    localparam logic [15:0] RST_LOAD_RES  = 16'd200;
    localparam logic [15:0] RST_AIR_FACT  = 16'd15360;

    typedef enum logic [1:0] {
        MODE_NC      = 2'd0,
        MODE_PREHEAT = 2'd1,
        MODE_CAL     = 2'd2,
        MODE_READY   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        OP_RS    = 2'd0,
        OP_AVG   = 2'd1,
        OP_RO    = 2'd2,
        OP_RATIO = 2'd3
    } t_div_op;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } t_div_rsp;

    // clamp a wide quotient to 32 bits
    function automatic logic [31:0] sat32(input logic [DIV_NUM_W-1:0] v);
        logic [31:0] r;
        r = (|v[DIV_NUM_W-1:32]) ? 32'hFFFF_FFFF : v[31:0];
        return r;
    endfunction

endpackage

// ===== hw/rtl/gscal_div.sv =====
// ----------------------------------------------------------------------------
// gscal_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module gscal_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gscal_pkg::t_div_req i_req,
    output gscal_pkg::t_div_rsp o_rsp
);

    localparam int NW = gscal_pkg::DIV_NUM_W;
    localparam int DW = gscal_pkg::DIV_DEN_W;
    localparam int CW = gscal_pkg::DIV_CNT_W;

    logic [DW:0]   r_rem;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW:0]   rem_sh;
    logic          ge;

    always_comb begin
        rem_sh = {r_rem[DW-1:0], r_quo[NW-1]};
        ge     = rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
            r_quo <= {r_quo[NW-2:0], ge};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

// ===== hw/rtl/gas_sensor_calibration_fsm.sv =====
// ----------------------------------------------------------------------------
// gas_sensor_calibration_fsm
// preheat, calibration and ratio tracking for a resistive gas sensor
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       sink       i_in_valid / o_in_stall i_adc_sample, i_now_ms
//  out      source     o_out_valid/ i_out_stall status, average flag, rs, ro, ratio
//  cfg      sink       i_cfg_valid/ o_cfg_ready i_cfg_index, i_cfg_data
//
//  one beat at a time: a resistance sample adds a multiply, a divider pass and
//  a count check, and every further pass through the shared 48-bit divider
//  (average, ro, ratio) adds another; the serial divider sets the beat length
//  synchronous active-low reset, no clearing pass; configuration and sequencer registers go to defaults
//  o_in_stall is high from acceptance until the result is loaded into the
//  output register; a stalled output holds the sequencer in its last state
// ----------------------------------------------------------------------------
module gas_sensor_calibration_fsm #(
    parameter int ADC_BITS = gscal_pkg::ADC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input beats
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [gscal_pkg::ADC_PORT_W-1:0]    i_adc_sample,
    input  logic [31:0]                         i_now_ms,
    // result beats
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_sensor_status,
    output logic                                o_average_done,
    output logic [31:0]                         o_rs_value,
    output logic [31:0]                         o_ro_value,
    output logic                                o_ratio_valid,
    output logic [31:0]                         o_res_ratio,
    // register writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gscal_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gscal_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int AW = ADC_BITS;
    localparam int PW = 16 + AW;                    // load resistor times headroom
    localparam logic [AW-1:0] FS = {AW{1'b1}};      // full scale reading

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECIDE = 7'b0000010,
        S_MUL    = 7'b0000100,
        S_DIV    = 7'b0001000,
        S_CHK    = 7'b0010000,
        S_RATIO  = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    // configuration registers
    logic [9:0]  r_thr;
    logic [11:0] r_pre_s;
    logic [15:0] r_intv;
    logic [7:0]  r_count;
    logic [15:0] r_rl;
    logic [15:0] r_fac;

    // sequencer and algorithm state
    t_state                       r_state;
    gscal_pkg::t_mode             r_mode;
    gscal_pkg::t_div_op           r_op;
    logic [31:0]                  r_mark;
    logic [AW-1:0]                r_prev;
    logic [gscal_pkg::SUM_W-1:0]  r_sum;
    logic [gscal_pkg::CNT_W-1:0]  r_taken;
    logic [31:0]                  r_ro;
    logic [31:0]                  r_rs;
    logic                         r_rs_ok;

    // per-beat working registers
    logic [AW-1:0]  r_adc;
    logic [31:0]    r_now;
    logic           r_avg_done;
    logic           r_rv;
    logic [31:0]    r_ratio;
    logic           r_start;
    logic [gscal_pkg::DIV_NUM_W-1:0] r_num;
    logic [gscal_pkg::DIV_DEN_W-1:0] r_den;

    // output register
    logic        r_out_valid;
    logic [1:0]  r_o_status;
    logic        r_o_done;
    logic [31:0] r_o_rs;
    logic [31:0] r_o_ro;
    logic        r_o_rv;
    logic [31:0] r_o_ratio;

    gscal_pkg::t_div_req div_req;
    gscal_pkg::t_div_rsp div_rsp;

    logic [15:0] adc_wide;
    logic [AW-1:0] adc_in;
    logic        in_take;
    logic [31:0] elapsed;
    logic [31:0] pre_ms;
    logic [AW-1:0] diff;
    logic [7:0]  div_cnt;
    logic [15:0] fac_eff;
    logic [31:0] quo_sat;

    assign adc_wide = 16'(i_adc_sample);
    assign adc_in   = adc_wide[AW-1:0];
    assign in_take  = i_in_valid && !o_in_stall;
    assign elapsed  = r_now - r_mark;
    assign pre_ms   = 32'(r_pre_s * 10'(gscal_pkg::MS_PER_S));
    assign diff     = (r_adc > r_prev) ? (r_adc - r_prev) : (r_prev - r_adc);
    assign div_cnt  = (r_count == '0) ? 8'd1 : r_count;
    assign fac_eff  = (r_fac == '0) ? 16'd1 : r_fac;
    assign quo_sat  = gscal_pkg::sat32(div_rsp.quo);

    assign div_req.start = r_start;
    assign div_req.num   = r_num;
    assign div_req.den   = r_den;

    gscal_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= gscal_pkg::RST_THRESHOLD;
            r_pre_s <= gscal_pkg::RST_PREHEAT;
            r_intv  <= gscal_pkg::RST_INTERVAL;
            r_count <= gscal_pkg::RST_COUNT;
            r_rl    <= gscal_pkg::RST_LOAD_RES;
            r_fac   <= gscal_pkg::RST_AIR_FACT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gscal_pkg::CFG_THRESHOLD: r_thr   <= i_cfg_data[9:0];
                gscal_pkg::CFG_PREHEAT:   r_pre_s <= i_cfg_data[11:0];
                gscal_pkg::CFG_INTERVAL:  r_intv  <= i_cfg_data;
                gscal_pkg::CFG_COUNT:     r_count <= i_cfg_data[7:0];
                gscal_pkg::CFG_LOAD_RES:  r_rl    <= i_cfg_data;
                gscal_pkg::CFG_AIR_FACT:  r_fac   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= gscal_pkg::MODE_NC;
            r_op        <= gscal_pkg::OP_RS;
            r_mark      <= '0;
            r_prev      <= '0;
            r_sum       <= '0;
            r_taken     <= '0;
            r_ro        <= '0;
            r_rs        <= '0;
            r_rs_ok     <= 1'b0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            // output register fills from the sequencer or empties on a taken beat
            if ((r_state == S_OUT) && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_adc      <= adc_in;
                        r_now      <= i_now_ms;
                        r_avg_done <= 1'b0;
                        r_state    <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_state <= S_RATIO;
                    if (16'(r_adc) >= 16'(r_thr)) begin
                        r_mode <= gscal_pkg::MODE_NC;
                    end else begin
                        case (r_mode)
                            gscal_pkg::MODE_NC: begin
                                r_mode <= gscal_pkg::MODE_PREHEAT;
                                r_mark <= r_now;
                                r_prev <= r_adc;
                            end
                            gscal_pkg::MODE_PREHEAT: begin
                                if (diff > AW'(1)) begin
                                    r_mark <= r_now;
                                    r_prev <= r_adc;
                                end else if (elapsed >= pre_ms) begin
                                    r_mode  <= gscal_pkg::MODE_CAL;
                                    r_sum   <= '0;
                                    r_taken <= '0;
                                    r_mark  <= r_now;
                                end
                            end
                            default: begin
                                // calibration and ready both sample
                                if (elapsed >= 32'(r_intv)) begin
                                    r_mark  <= r_now;
                                    r_state <= S_MUL;
                                end
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    r_state <= S_DIV;
                    r_op    <= gscal_pkg::OP_RS;
                    r_start <= 1'b1;
                    r_num   <= gscal_pkg::DIV_NUM_W'(
                                   {PW'(r_rl * (FS - r_adc)), 16'h0000});
                    r_den   <= gscal_pkg::DIV_DEN_W'(r_adc);
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        case (r_op)
                            gscal_pkg::OP_RS: begin
                                r_sum   <= r_sum + gscal_pkg::SUM_W'(quo_sat);
                                r_taken <= r_taken + 1'b1;
                                r_state <= S_CHK;
                            end
                            gscal_pkg::OP_AVG: begin
                                r_sum      <= '0;
                                r_taken    <= '0;
                                r_avg_done <= 1'b1;
                                if (r_mode == gscal_pkg::MODE_CAL) begin
                                    r_op    <= gscal_pkg::OP_RO;
                                    r_start <= 1'b1;
                                    r_num   <= gscal_pkg::DIV_NUM_W'({quo_sat, 8'h00});
                                    r_den   <= gscal_pkg::DIV_DEN_W'(fac_eff);
                                end else begin
                                    r_rs    <= quo_sat;
                                    r_rs_ok <= 1'b1;
                                    r_state <= S_RATIO;
                                end
                            end
                            gscal_pkg::OP_RO: begin
                                r_ro    <= quo_sat;
                                r_mode  <= gscal_pkg::MODE_READY;
                                r_state <= S_RATIO;
                            end
                            default: begin
                                r_ratio <= quo_sat;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_CHK: begin
                    if (r_taken > gscal_pkg::CNT_W'(div_cnt)) begin
                        r_op    <= gscal_pkg::OP_AVG;
                        r_start <= 1'b1;
                        r_num   <= gscal_pkg::DIV_NUM_W'(r_sum);
                        r_den   <= gscal_pkg::DIV_DEN_W'(div_cnt);
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_RATIO;
                    end
                end
                S_RATIO: begin
                    // a zero reference divides to all ones
                    r_rv    <= (r_mode == gscal_pkg::MODE_READY) && r_rs_ok;
                    r_ratio <= '0;
                    if ((r_mode == gscal_pkg::MODE_READY) && r_rs_ok) begin
                        r_op    <= gscal_pkg::OP_RATIO;
                        r_start <= 1'b1;
                        r_num   <= gscal_pkg::DIV_NUM_W'({r_rs, 16'h0000});
                        r_den   <= r_ro;
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result payload, loaded as the beat leaves the sequencer
    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && (!r_out_valid || !i_out_stall)) begin
            r_o_status <= r_mode;
            r_o_done   <= r_avg_done;
            r_o_rs     <= r_rs;
            r_o_ro     <= r_ro;
            r_o_rv     <= r_rv;
            r_o_ratio  <= r_ratio;
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_sensor_status = r_o_status;
    assign o_average_done  = r_o_done;
    assign o_rs_value      = r_o_rs;
    assign o_ro_value      = r_o_ro;
    assign o_ratio_valid   = r_o_rv;
    assign o_res_ratio     = r_o_ratio;

endmodule
